>>> hw/rtl/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants of the frame acceptance core
// Beat structs, command kinds, outcome codes and register indexes.
// ----------------------------------------------------------------------------
package fac_pkg;

	// one input beat: a telecommand frame header
	typedef struct packed {
		logic       frame_valid;
		logic       bypass;
		logic       control;
		logic [7:0] seq_num;
		logic [7:0] cmd_first;
		logic [7:0] cmd_second;
		logic [7:0] cmd_new_vr;
		logic       buffer_ready;
	} in_beat_t;

	// one result beat
	typedef struct packed {
		logic [3:0]  outcome;
		logic        deliver;
		logic [31:0] clcw_word;
	} out_beat_t;

	// frame kind as decoded by the front end
	localparam logic [2:0] KIND_INVALID  = 3'd0;
	localparam logic [2:0] KIND_UNLOCK   = 3'd1;
	localparam logic [2:0] KIND_SETVR    = 3'd2;
	localparam logic [2:0] KIND_BAD_CMD  = 3'd3;
	localparam logic [2:0] KIND_BYP_DATA = 3'd4;
	localparam logic [2:0] KIND_TYPE_A   = 3'd5;

	// queue entry: kind plus the fields the back end still needs
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] seq_num;
		logic [7:0] new_vr;
		logic       buffer_ready;
	} q_entry_t;

	// control command bytes
	localparam logic [7:0] CMD_UNLOCK_BYTE = 8'h00;
	localparam logic [7:0] CMD_SETVR_BYTE  = 8'h82;
	localparam logic [7:0] CMD_SETVR_TAIL  = 8'h00;
	localparam logic [1:0] COP_IN_EFFECT   = 2'd1;

	// outcome codes
	localparam logic [3:0] OUT_ACCEPTED    = 4'd0;
	localparam logic [3:0] OUT_NO_BUFFER   = 4'd1;
	localparam logic [3:0] OUT_POS_WINDOW  = 4'd2;
	localparam logic [3:0] OUT_NEG_WINDOW  = 4'd3;
	localparam logic [3:0] OUT_LOCKOUT     = 4'd4;
	localparam logic [3:0] OUT_LOCKED      = 4'd5;
	localparam logic [3:0] OUT_UNLOCKED    = 4'd6;
	localparam logic [3:0] OUT_SETVR       = 4'd7;
	localparam logic [3:0] OUT_SETVR_REF   = 4'd8;
	localparam logic [3:0] OUT_BAD_CMD     = 4'd9;
	localparam logic [3:0] OUT_BYPASS_DATA = 4'd10;
	localparam logic [3:0] OUT_INVALID     = 4'd11;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_ID   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_WIDTH = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LINK_STATUS  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_NO_RF        = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_NO_BITLOCK   = 3'd4;

	localparam logic [7:0] WINDOW_WIDTH_RESET = 8'd10;

endpackage

>>> hw/rtl/fac_front.sv
// ----------------------------------------------------------------------------
// fac_front: frame header classifier
// Decode the header into a frame kind, independent of receiver state.
// ----------------------------------------------------------------------------
module fac_front (
	input  fac_pkg::in_beat_t hdr,
	output fac_pkg::q_entry_t entry
);
	import fac_pkg::*;

	logic [2:0] kind;

	always_comb begin
		if (!hdr.frame_valid) begin
			kind = KIND_INVALID;
		end else if (!hdr.bypass) begin
			// control flag on a type-A frame is ignored
			kind = KIND_TYPE_A;
		end else if (!hdr.control) begin
			kind = KIND_BYP_DATA;
		end else if (hdr.cmd_first == CMD_UNLOCK_BYTE) begin
			kind = KIND_UNLOCK;
		end else if (hdr.cmd_first == CMD_SETVR_BYTE && hdr.cmd_second == CMD_SETVR_TAIL) begin
			kind = KIND_SETVR;
		end else begin
			kind = KIND_BAD_CMD;
		end
	end

	assign entry.kind         = kind;
	assign entry.seq_num      = hdr.seq_num;
	assign entry.new_vr       = hdr.cmd_new_vr;
	assign entry.buffer_ready = hdr.buffer_ready;

endmodule

>>> hw/rtl/fac_queue.sv
// ----------------------------------------------------------------------------
// fac_queue: decoupling FIFO between classifier and executor
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fac_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fac_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output fac_pkg::q_entry_t head
);
	import fac_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t               mem [DEPTH];
	logic     [PTR_W-1:0]   wr_ptr_q;
	logic     [PTR_W-1:0]   rd_ptr_q;
	logic     [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/fac_back.sv
// ----------------------------------------------------------------------------
// fac_back: FARM-1 executor
// Hold receiver state and configuration, apply each queued frame, register
// the outcome and the control word.
// ----------------------------------------------------------------------------
module fac_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fac_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           head_valid,
	input  fac_pkg::q_entry_t              head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output fac_pkg::out_beat_t             out_data
);
	import fac_pkg::*;

	// configuration
	logic [5:0] channel_id_q;
	logic [7:0] window_width_q;
	logic [2:0] link_status_q;
	logic       no_rf_q;
	logic       no_bitlock_q;

	// receiver state
	logic       lockout_q;
	logic       wait_q;
	logic       retransmit_q;
	logic [1:0] farmb_q;
	logic [7:0] vr_q;

	logic       lockout_n;
	logic       wait_n;
	logic       retransmit_n;
	logic [1:0] farmb_n;
	logic [7:0] vr_n;
	logic [3:0] outcome_n;
	logic       deliver_n;

	logic [6:0] half;
	logic [7:0] pos_edge;
	logic [7:0] neg_edge;

	logic       out_valid_q;
	out_beat_t  out_q;

	function automatic logic in_wrapped(input logic [7:0] lo, input logic [7:0] v,
			input logic [7:0] hi);
		if (hi < lo) begin
			return (lo <= v) || (v <= hi);
		end
		return (lo <= v) && (v <= hi);
	endfunction

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign half     = window_width_q[7:1];
	assign pos_edge = vr_q + {1'b0, half} - 8'd1;
	assign neg_edge = vr_q - {1'b0, half};

	always_comb begin
		lockout_n    = lockout_q;
		wait_n       = wait_q;
		retransmit_n = retransmit_q;
		farmb_n      = farmb_q;
		vr_n         = vr_q;
		outcome_n    = OUT_INVALID;
		deliver_n    = 1'b0;
		case (head.kind)
			KIND_UNLOCK: begin
				retransmit_n = 1'b0;
				wait_n       = 1'b0;
				lockout_n    = 1'b0;
				farmb_n      = farmb_q + 2'd1;
				outcome_n    = OUT_UNLOCKED;
			end
			KIND_SETVR: begin
				if (!lockout_q) begin
					retransmit_n = 1'b0;
					wait_n       = 1'b0;
					vr_n         = head.new_vr;
					outcome_n    = OUT_SETVR;
				end else begin
					outcome_n = OUT_SETVR_REF;
				end
				farmb_n = farmb_q + 2'd1;
			end
			KIND_BAD_CMD: begin
				outcome_n = OUT_BAD_CMD;
			end
			KIND_BYP_DATA: begin
				farmb_n   = farmb_q + 2'd1;
				deliver_n = 1'b1;
				outcome_n = OUT_BYPASS_DATA;
			end
			KIND_TYPE_A: begin
				if (lockout_q) begin
					outcome_n = OUT_LOCKED;
				end else if (head.seq_num == vr_q) begin
					if (head.buffer_ready) begin
						wait_n       = 1'b0;
						retransmit_n = 1'b0;
						vr_n         = vr_q + 8'd1;
						deliver_n    = 1'b1;
						outcome_n    = OUT_ACCEPTED;
					end else begin
						wait_n       = 1'b1;
						retransmit_n = 1'b1;
						outcome_n    = OUT_NO_BUFFER;
					end
				end else if (in_wrapped(vr_q, head.seq_num, pos_edge)) begin
					retransmit_n = 1'b1;
					outcome_n    = OUT_POS_WINDOW;
				end else if (in_wrapped(neg_edge, head.seq_num, vr_q)) begin
					outcome_n = OUT_NEG_WINDOW;
				end else begin
					lockout_n = 1'b1;
					outcome_n = OUT_LOCKOUT;
				end
			end
			default: begin
				outcome_n = OUT_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q   <= '0;
			window_width_q <= WINDOW_WIDTH_RESET;
			link_status_q  <= '0;
			no_rf_q        <= 1'b0;
			no_bitlock_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CHANNEL_ID:   channel_id_q   <= cfg_wdata[5:0];
				REG_WINDOW_WIDTH: window_width_q <= cfg_wdata[7:0];
				REG_LINK_STATUS:  link_status_q  <= cfg_wdata[2:0];
				REG_NO_RF:        no_rf_q        <= cfg_wdata[0];
				REG_NO_BITLOCK:   no_bitlock_q   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q    <= 1'b0;
			wait_q       <= 1'b0;
			retransmit_q <= 1'b0;
			farmb_q      <= '0;
			vr_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				lockout_q    <= lockout_n;
				wait_q       <= wait_n;
				retransmit_q <= retransmit_n;
				farmb_q      <= farmb_n;
				vr_q         <= vr_n;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.outcome   <= outcome_n;
			out_q.deliver   <= deliver_n;
			out_q.clcw_word <= {1'b0, 2'b00, link_status_q, COP_IN_EFFECT,
				channel_id_q, 2'b00, no_rf_q, no_bitlock_q, lockout_n, wait_n,
				retransmit_n, farmb_n, 1'b0, vr_n};
		end
	end

	a_invalid_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.kind == KIND_INVALID |=>
		$stable(lockout_q) && $stable(wait_q) && $stable(retransmit_q) &&
		$stable(farmb_q) && $stable(vr_q))
		else $error("invalid frame changed receiver state");

	a_farmb_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(farmb_q))
		else $error("FARM-B counter moved without a frame");

	a_lockout_from_type_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lockout_q) |-> $past(pop && head.kind == KIND_TYPE_A))
		else $error("lockout entered by a non type-A frame");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop))
		else $error("result beat appeared without a dequeued frame");

	a_no_pop_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !pop)
		else $error("frame dequeued while a result is held");

endmodule

>>> hw/rtl/farm1_frame_acceptance_core.sv
// ----------------------------------------------------------------------------
// farm1_frame_acceptance_core: FARM-1 frame acceptance and reporting
// Receiver side of COP-1: classify telecommand frame headers, run the
// sliding-window check and Unlock / Set V(R) commands, report the CLCW.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   -------  ---  ---------------------  ---------------------------------
//   in       rx   in_valid / in_stall    fac_pkg::in_beat_t  (frame header)
//   out      tx   out_valid / out_stall  fac_pkg::out_beat_t (outcome, CLCW)
//   cfg      rx   cfg_we                 cfg_addr, cfg_wdata (write only)
//
// Throughput is one frame per cycle while the output does not stall; the
// executor applies a frame and packs the control word together against the
// live V(R) and flags. A header is decoded into the queue when it is
// accepted and applied into the output register from the queue head.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; a stall on
// the output holds the result register and backs up into the queue.
// Reset clears the receiver state, the queue and the output valid flag, and
// loads the configuration registers with their defaults (window width 10).
//
module farm1_frame_acceptance_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  fac_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output fac_pkg::out_beat_t             out_data,
	input  logic                           cfg_we,
	input  logic [fac_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fac_pkg::*;

	q_entry_t entry;
	q_entry_t head;
	logic     q_full;
	logic     head_valid;
	logic     pop;
	logic     push;

	// decode the header as it arrives; nothing here depends on V(R)
	fac_front u_front (
		.hdr   (in_data),
		.entry (entry)
	);

	// take a beat whenever the queue has room, regardless of the back end
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	fac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// apply frames in order and hold the result until it is taken
	fac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
